### design/rmf_pkg.sv
// Package with the shared types and constants of the running median filter.
`default_nettype none

package rmf_pkg;

  // Width and reset value of the window length register.
  localparam int CFG_LEN_W     = 6;
  localparam int CFG_LEN_RESET = 5;

  // Controls that the top level hands to every cell in the chain.
  typedef struct packed {
    logic shift;  // a new sample enters the chain
    logic cmp;    // probes rotate and cells count smaller keys
  } rmf_cell_ctl_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_SEL  = 4'b0100,
    ST_DONE = 4'b1000
  } rmf_state_t;

endpackage : rmf_pkg

`default_nettype wire

### design/rmf_cell.sv
// One window cell: holds a sample, a rotating probe, and the rank of its sample.
`default_nettype none

module rmf_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 5,
  parameter int CELL_IDX     = 0
) (
  input  wire logic                       clk,
  input  wire rmf_pkg::rmf_cell_ctl_t     ctl,
  input  wire logic [SAMPLE_WIDTH-1:0]    val_in,
  output logic      [SAMPLE_WIDTH-1:0]    val_out,
  input  wire logic [SAMPLE_WIDTH-1:0]    probe_val_in,
  input  wire logic [IDX_W-1:0]           probe_idx_in,
  output logic      [SAMPLE_WIDTH-1:0]    probe_val_out,
  output logic      [IDX_W-1:0]           probe_idx_out,
  output logic      [IDX_W-1:0]           rank_out
);
  import rmf_pkg::*;

  logic [SAMPLE_WIDTH-1:0] val_r;
  logic [SAMPLE_WIDTH-1:0] probe_val_r;
  logic [IDX_W-1:0]        probe_idx_r;
  logic [IDX_W-1:0]        rank_r;
  logic                    probe_less;

  // The probe key is smaller when its value is smaller, or equal with a lower position.
  // The position breaks ties so every cell in the window gets a distinct rank.
  assign probe_less = ($signed(probe_val_r) < $signed(val_r)) ||
                      ((probe_val_r == val_r) && (probe_idx_r < IDX_W'(CELL_IDX)));

  // Shift in a new sample, or rotate the probe and count smaller keys.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r       <= val_in;
      probe_val_r <= val_in;
      probe_idx_r <= IDX_W'(CELL_IDX);
      rank_r      <= '0;
    end else if (ctl.cmp) begin
      probe_val_r <= probe_val_in;
      probe_idx_r <= probe_idx_in;
      if (probe_less) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  assign val_out       = val_r;
  assign probe_val_out = probe_val_r;
  assign probe_idx_out = probe_idx_r;
  assign rank_out      = rank_r;

endmodule : rmf_cell

`default_nettype wire

### design/running_median_filter.sv
// Top level of the sliding-window median filter built on a chain of rank cells.
//
//  Channel | Ports              | Contents (lowest bit first)
//  --------+--------------------+---------------------------------------------
//  in      | in_tvalid/tready   | tdata: sample; tuser: start_of_series
//  out     | out_tvalid/tready  | tdata: median_twice; tuser: median_valid
//  cfg     | cfg_tvalid/tready  | tdata: window_length (6 bits)
//
// When the window is full an item passes through these steps: shift the sample into
// the cell chain, rotate the probes around the chain, pick and add the middle
// values, and hand off to the output. While the window is still filling an item
// goes from the shift straight to the hand-off.
// Reset (rst_n low, synchronous) empties the output, sets the length to 5, and
// zeros the fill count. A stalled output holds its transaction while the chain
// already works on the next sample.
`default_nettype none

module running_median_filter #(
  parameter int WINDOW_MAX   = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // in_tdata: sample
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  // in_tuser: start_of_series
  input  wire logic                                    in_tuser,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  // out_tdata: median_twice
  output logic      [((SAMPLE_WIDTH+8)/8)*8-1:0]       out_tdata,
  // out_tuser: median_valid
  output logic                                         out_tuser,
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  // cfg_tdata: window_length
  input  wire logic [7:0]                              cfg_tdata,
  input  wire logic                                    cfg_tvalid,
  output logic                                         cfg_tready
);
  import rmf_pkg::*;

  localparam int OUT_DW = ((SAMPLE_WIDTH + 8) / 8) * 8;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  rmf_state_t              state_r, state_nxt;
  logic [CFG_LEN_W-1:0]    cfg_len_r;
  logic [LEN_W-1:0]        fill_r, fill_nxt, fill_base;
  logic [LEN_W-1:0]        eff_len;
  logic [LEN_W-1:0]        cnt_r;
  logic                    res_valid_r;
  logic [SAMPLE_WIDTH:0]   res_med_r;
  logic                    out_tvalid_r;
  logic                    out_tuser_r;
  logic [SAMPLE_WIDTH:0]   out_med_r;
  logic                    in_xact;
  logic                    out_load;
  rmf_cell_ctl_t           cell_ctl;
  logic [IDX_W-1:0]        tgt_hi, tgt_lo;
  logic [SAMPLE_WIDTH-1:0] lo_val, hi_val;
  logic [SAMPLE_WIDTH:0]   med_sum;

  logic [SAMPLE_WIDTH-1:0] val_w       [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] probe_val_w [WINDOW_MAX];
  logic [IDX_W-1:0]        probe_idx_w [WINDOW_MAX];
  logic [IDX_W-1:0]        rank_w      [WINDOW_MAX];

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_xact    = in_tvalid && in_tready;

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= CFG_LEN_W'(CFG_LEN_RESET);
    end else if (cfg_tvalid && cfg_tready) begin
      cfg_len_r <= cfg_tdata[CFG_LEN_W-1:0];
    end
  end

  // Effective length: zero counts as one, large values clip to the chain length.
  always_comb begin
    if (cfg_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(cfg_len_r) > WINDOW_MAX) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(cfg_len_r);
    end
  end

  // Fill count after this sample, restarting on start_of_series and saturating at the chain length.
  always_comb begin
    fill_base = in_tuser ? '0 : fill_r;
    fill_nxt  = (fill_base != LEN_W'(WINDOW_MAX)) ? fill_base + 1'b1 : fill_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_xact) begin
      fill_r <= fill_nxt;
    end
  end

  // Cell controls.
  assign cell_ctl.shift = in_xact;
  assign cell_ctl.cmp   = (state_r == ST_CMP);

  // The chain of cells; probes rotate within the first eff_len cells.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] cell_val_in;
    logic [SAMPLE_WIDTH-1:0] cell_pv_in;
    logic [IDX_W-1:0]        cell_pi_in;

    if (i == 0) begin : g_head
      assign cell_val_in = in_tdata[SAMPLE_WIDTH-1:0];
    end else begin : g_body
      assign cell_val_in = val_w[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign cell_pv_in = probe_val_w[0];
      assign cell_pi_in = probe_idx_w[0];
    end else begin : g_mid
      assign cell_pv_in = (LEN_W'(i) == eff_len - 1'b1) ? probe_val_w[0] : probe_val_w[i+1];
      assign cell_pi_in = (LEN_W'(i) == eff_len - 1'b1) ? probe_idx_w[0] : probe_idx_w[i+1];
    end

    rmf_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IDX_W        (IDX_W),
      .CELL_IDX     (i)
    ) u_cell (
      .clk           (clk),
      .ctl           (cell_ctl),
      .val_in        (cell_val_in),
      .val_out       (val_w[i]),
      .probe_val_in  (cell_pv_in),
      .probe_idx_in  (cell_pi_in),
      .probe_val_out (probe_val_w[i]),
      .probe_idx_out (probe_idx_w[i]),
      .rank_out      (rank_w[i])
    );
  end

  // Middle ranks: equal for odd lengths, adjacent for even lengths.
  assign tgt_hi = IDX_W'(eff_len >> 1);
  assign tgt_lo = eff_len[0] ? tgt_hi : tgt_hi - 1'b1;

  // Pick the cells that hold the middle ranks inside the window.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (LEN_W'(i) < eff_len) begin
        if (rank_w[i] == tgt_lo) begin
          lo_val = lo_val | val_w[i];
        end
        if (rank_w[i] == tgt_hi) begin
          hi_val = hi_val | val_w[i];
        end
      end
    end
  end

  assign med_sum = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};

  // The output register is free, or frees up in this cycle.
  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xact) begin
          state_nxt = (fill_nxt >= eff_len) ? ST_CMP : ST_DONE;
        end
      end
      ST_CMP: begin
        if (cnt_r == eff_len - 1'b1) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Rotation counter and result register.
  always_ff @(posedge clk) begin
    if (in_xact) begin
      cnt_r       <= '0;
      res_valid_r <= (fill_nxt >= eff_len);
      res_med_r   <= '0;
    end else if (state_r == ST_CMP) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (state_r == ST_SEL) begin
      res_med_r <= med_sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tuser_r <= res_valid_r;
      out_med_r   <= res_med_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = OUT_DW'(out_med_r);

endmodule : running_median_filter

`default_nettype wire

### design/rmf_checker.sv
// Port-level checks for the running median filter, bound to its top level.
`default_nettype none

module rmf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [((SAMPLE_WIDTH+8)/8)*8-1:0]   out_tdata,
  input wire logic                                out_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A result from a window that is not yet full carries zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("padding result is not zero");

  // Reset empties the output.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // The filter works on one sample at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in two consecutive cycles");

endmodule : rmf_checker

bind running_median_filter rmf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
